/* src/pmwu_pkg.sv */
// ----------------------------------------------------------------------------
// pmwu_pkg
// shared constants, types and the numeric digit table for the pocsag
// message word unpacker
// ----------------------------------------------------------------------------
package pmwu_pkg;

  // data bits carried by one codeword (8..32)
  localparam int DATA_BITS = 20;
  localparam int CHAR_BITS = 7;
  localparam int NIBBLE_BITS = 4;
  localparam int DIGITS = DATA_BITS / NIBBLE_BITS;

  // remaining-bit counter must hold DATA_BITS itself
  localparam int REM_W = $clog2(DATA_BITS + 1);
  localparam int DIG_W = (DIGITS > 1) ? $clog2(DIGITS) : 1;
  localparam int CNT_W = $clog2(CHAR_BITS);

  // codeword kinds
  localparam logic [1:0] MODE_ADDRESS = 2'd0;
  localparam logic [1:0] MODE_IDLE    = 2'd1;
  localparam logic [1:0] MODE_MESSAGE = 2'd2;

  // symbol kinds
  localparam logic KIND_ALPHA = 1'b0;
  localparam logic KIND_DIGIT = 1'b1;

  // queue status between the front and the back
  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

  // numeric paging digit table: 0-9 * U space - ) (
  function automatic logic [CHAR_BITS-1:0] digit_char(input logic [NIBBLE_BITS-1:0] nib);
    logic [CHAR_BITS-1:0] c;
    unique case (nib)
      4'hA:    c = 7'h2A;  // '*'
      4'hB:    c = 7'h55;  // 'U'
      4'hC:    c = 7'h20;  // space
      4'hD:    c = 7'h2D;  // '-'
      4'hE:    c = 7'h29;  // ')'
      4'hF:    c = 7'h28;  // '('
      default: c = 7'h30 | {3'b000, nib};  // '0'..'9'
    endcase
    return c;
  endfunction

endpackage

/* src/pmwu_if.sv */
// ----------------------------------------------------------------------------
// pmwu_if
// valid/ready channels: codewords in, symbols out
// ----------------------------------------------------------------------------
interface pmwu_code_if;
  logic                           valid;
  logic                           ready;
  logic [1:0]                     mode;
  logic [pmwu_pkg::DATA_BITS-1:0] payload;

  modport source (output valid, output mode, output payload, input ready);
  modport sink   (input valid, input mode, input payload, output ready);
endinterface

interface pmwu_sym_if;
  logic                           valid;
  logic                           ready;
  logic                           symbol_kind;
  logic [pmwu_pkg::CHAR_BITS-1:0] symbol;
  logic                           last;

  modport source (output valid, output symbol_kind, output symbol, output last, input ready);
  modport sink   (input valid, input symbol_kind, input symbol, input last, output ready);
endinterface

/* src/pocsag_message_word_unpacker_core.sv */
// ----------------------------------------------------------------------------
// pocsag_message_word_unpacker_core
// pocsag codeword unpacker: alphanumeric characters and numeric digits
// ----------------------------------------------------------------------------
// a message word's first symbol passes the queue entry, the back's word registers and the output register
// throughput: a message word gives 7 or 8 symbols, one per cycle while the output
//   is not stalled; address and idle words are accepted but never reach the queue
// the 2-entry queue lets codewords be accepted while symbols still drain
// reset (rst, synchronous): queue emptied, assembler and flags cleared
// ----------------------------------------------------------------------------
module pocsag_message_word_unpacker_core (
  input  logic         clk,
  input  logic         rst,
  pmwu_code_if.sink    code,
  pmwu_sym_if.source   sym
);

  // front to queue
  logic                           push;
  logic [pmwu_pkg::DATA_BITS-1:0] push_data;

  // queue to back
  logic                           pop;
  logic [pmwu_pkg::DATA_BITS-1:0] head;
  pmwu_pkg::q_stat_t              stat;

  // front: takes every kind of codeword while the queue is not full, queues only message words
  pmwu_front u_front (
    .clk       (clk),
    .rst       (rst),
    .code      (code),
    .stat      (stat),
    .push      (push),
    .push_data (push_data)
  );

  // decouples acceptance from symbol emission
  pmwu_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .stat      (stat)
  );

  // back: character assembly, then digit mapping, through an output register
  pmwu_back u_back (
    .clk  (clk),
    .rst  (rst),
    .head (head),
    .stat (stat),
    .pop  (pop),
    .sym  (sym)
  );

endmodule

/* src/pmwu_queue.sv */
// ----------------------------------------------------------------------------
// pmwu_queue
// two-entry queue of message payloads between front and back
// ----------------------------------------------------------------------------
module pmwu_queue (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           push,
  input  logic [pmwu_pkg::DATA_BITS-1:0] push_data,
  input  logic                           pop,
  output logic [pmwu_pkg::DATA_BITS-1:0] head,
  output pmwu_pkg::q_stat_t              stat
);

  logic [pmwu_pkg::DATA_BITS-1:0] mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign stat.empty = (count == 2'd0);
  assign stat.full  = (count == 2'd2);
  assign head       = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

/* src/pmwu_front.sv */
// ----------------------------------------------------------------------------
// pmwu_front
// accepts codewords, tracks address/data flags, queues message payloads
// ----------------------------------------------------------------------------
module pmwu_front (
  input  logic                           clk,
  input  logic                           rst,
  pmwu_code_if.sink                      code,
  input  pmwu_pkg::q_stat_t              stat,
  output logic                           push,
  output logic [pmwu_pkg::DATA_BITS-1:0] push_data
);

  logic address_valid;
  logic data_seen;
  logic accept;
  logic is_msg;

  assign code.ready = ~stat.full;
  assign accept     = code.valid & code.ready;
  assign is_msg     = (code.mode == pmwu_pkg::MODE_MESSAGE);
  assign push       = accept & is_msg;
  assign push_data  = code.payload;

  always_ff @(posedge clk) begin
    if (rst) begin
      address_valid <= 1'b0;
      data_seen     <= 1'b0;
    end else if (accept) begin
      unique case (code.mode)
        pmwu_pkg::MODE_ADDRESS: begin
          address_valid <= 1'b1;
        end
        pmwu_pkg::MODE_MESSAGE: begin
          address_valid <= 1'b1;
          data_seen     <= 1'b1;
        end
        default: begin
          // idle word and the unused code change nothing
        end
      endcase
    end
  end

  a_data_implies_addr: assert property (@(posedge clk) disable iff (rst)
    data_seen |-> address_valid)
    else $error("data flag set without address_valid");

  a_msg_sets_data: assert property (@(posedge clk) disable iff (rst)
    push |=> data_seen)
    else $error("message word did not set the data flag");

endmodule

/* src/pmwu_back.sv */
// ----------------------------------------------------------------------------
// pmwu_back
// unpacks one queued message word: characters, then numeric digits,
// one symbol per cycle while the output is not stalled, into the output register
// ----------------------------------------------------------------------------
module pmwu_back (
  input  logic                           clk,
  input  logic                           rst,
  input  logic [pmwu_pkg::DATA_BITS-1:0] head,
  input  pmwu_pkg::q_stat_t              stat,
  output logic                           pop,
  pmwu_sym_if.source                     sym
);

  localparam int DB = pmwu_pkg::DATA_BITS;
  localparam int CB = pmwu_pkg::CHAR_BITS;
  localparam int NB = pmwu_pkg::NIBBLE_BITS;

  logic                         busy;
  logic                         in_digits;
  logic [DB-1:0]                bits;
  logic [DB-1:0]                nibs;
  logic [pmwu_pkg::REM_W-1:0]   rem;
  logic [pmwu_pkg::DIG_W-1:0]   dcnt;
  logic [CB-1:0]                char_shift;
  logic [pmwu_pkg::CNT_W-1:0]   char_cnt;

  logic                         step;
  logic                         emit_char;
  logic                         step_last;
  logic [pmwu_pkg::CNT_W-1:0]   need;
  logic [pmwu_pkg::CNT_W-1:0]   tail_n;
  logic [CB-1:0]                window;
  logic [CB-1:0]                full_char;
  logic [CB-1:0]                tail_char;

  // next bits in arrival order: window[j] is the j-th bit still to come
  always_comb begin
    for (int j = 0; j < CB; j++) begin
      window[j] = bits[DB-1-j];
    end
  end

  assign need      = pmwu_pkg::CNT_W'(CB) - char_cnt;
  assign tail_n    = rem[pmwu_pkg::CNT_W-1:0];
  assign emit_char = ~in_digits & (rem >= pmwu_pkg::REM_W'(need));
  // old bits slide down, new bits land above them
  assign full_char = (char_shift >> need) | CB'(window << char_cnt);
  assign tail_char = (char_shift >> tail_n) | CB'(window << (pmwu_pkg::CNT_W'(CB) - tail_n));
  assign step_last = ~emit_char & (dcnt == pmwu_pkg::DIG_W'(pmwu_pkg::DIGITS - 1));
  assign step      = busy & (~sym.valid | sym.ready);
  assign pop       = ~stat.empty & (~busy | (step & step_last));

  always_ff @(posedge clk) begin
    if (step) begin
      if (emit_char) begin
        sym.symbol_kind <= pmwu_pkg::KIND_ALPHA;
        sym.symbol      <= full_char;
        sym.last        <= 1'b0;
      end else begin
        sym.symbol_kind <= pmwu_pkg::KIND_DIGIT;
        sym.symbol      <= pmwu_pkg::digit_char(nibs[DB-1 -: NB]);
        sym.last        <= step_last;
      end
    end
    if (pop) begin
      bits      <= head;
      nibs      <= head;
      rem       <= pmwu_pkg::REM_W'(DB);
      dcnt      <= '0;
      in_digits <= 1'b0;
    end else if (step) begin
      if (emit_char) begin
        bits <= bits << need;
        rem  <= rem - pmwu_pkg::REM_W'(need);
      end else begin
        nibs      <= nibs << NB;
        dcnt      <= dcnt + pmwu_pkg::DIG_W'(1);
        in_digits <= 1'b1;
        rem       <= '0;
      end
    end
    if (rst) begin
      busy       <= 1'b0;
      sym.valid  <= 1'b0;
      char_shift <= '0;
      char_cnt   <= '0;
    end else begin
      if (step) begin
        sym.valid <= 1'b1;
      end else if (sym.ready) begin
        sym.valid <= 1'b0;
      end
      if (step && emit_char) begin
        char_shift <= '0;
        char_cnt   <= '0;
      end else if (step && !in_digits) begin
        // leftover bits stay in the assembler for the next word
        char_shift <= tail_char;
        char_cnt   <= char_cnt + tail_n;
      end
      if (pop) begin
        busy <= 1'b1;
      end else if (step && step_last) begin
        busy <= 1'b0;
      end
    end
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    char_cnt < pmwu_pkg::CNT_W'(CB))
    else $error("character assembler overfilled");

  a_pop_free: assert property (@(posedge clk) disable iff (rst)
    pop |-> (!busy || (step && step_last)))
    else $error("new word loaded over a word in progress");

  a_tail_short: assert property (@(posedge clk) disable iff (rst)
    (step && !emit_char && !in_digits) |-> (rem < pmwu_pkg::REM_W'(need)))
    else $error("leftover bits would complete a character");

  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (step && step_last && !pop) |=> !busy)
    else $error("back still busy after final symbol");

endmodule
